// File: rtl/bfa_pkg.sv
package bfa_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int CAP_W     = 4;
  localparam int ID_W      = 12;
  localparam int HGT_W     = 8;
  localparam int AVG_STEPS = HGT_W;
  localparam int STEP_W    = $clog2(AVG_STEPS);

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
  } bfa_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } bfa_status_t;

endpackage

// File: rtl/bfa_ctrl.sv
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  bfa_status_t status,
  output bfa_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.apply    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = status.need_div ? ST_DIV : ST_APPLY;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/bfa_datapath.sv
module bfa_datapath
  import bfa_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bfa_cmd_t         cmd,
  output bfa_status_t      status,
  input  logic             in_req_type,
  input  logic [ID_W-1:0]  in_player_id,
  input  logic [HGT_W-1:0] in_height,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output logic             out_valid,
  output logic             out_avg_valid,
  output logic [HGT_W-1:0] out_avg_height,
  output logic             out_removed_valid,
  output logic [ID_W-1:0]  out_removed_id,
  output logic [HGT_W-1:0] out_removed_height,
  output logic             out_empty_error
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = HGT_W + CW;
  localparam int NW = SW + 1;
  localparam int RW = CW + 1;

  logic [ID_W-1:0]  id_mem  [DEPTH];
  logic [HGT_W-1:0] hgt_mem [DEPTH];
  logic [ID_W-1:0]  rd_id_r;
  logic [HGT_W-1:0] rd_hgt_r;

  logic [CAP_W-1:0] cap_r;
  logic [IW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;

  logic             req_r;
  logic [ID_W-1:0]  id_r;
  logic [HGT_W-1:0] hgt_r;

  logic [RW-1:0]     rem_r;
  logic [HGT_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic [NW-1:0]     num;
  logic [RW-1:0]     den;
  logic [RW:0]       trial;

  logic [CW-1:0] ecap;
  logic          evict, drop, is_enq;
  logic [IW-1:0] head_inc, head_a, tail;
  logic [CW-1:0] count_a;
  logic [SW-1:0] sum_a;
  logic [IW:0]   tail_sum;

  logic             out_valid_r;
  logic             avg_valid_r, removed_valid_r, empty_error_r;
  logic [HGT_W-1:0] avg_height_r, removed_height_r;
  logic [ID_W-1:0]  removed_id_r;

  always_comb begin
    if (cap_r == '0) begin
      ecap = CW'(1);
    end else if (int'(cap_r) > DEPTH) begin
      ecap = CW'(DEPTH);
    end else begin
      ecap = CW'(cap_r);
    end
  end

  assign num   = {sum_r, 1'b0} + NW'(count_r);
  assign den   = {count_r, 1'b0};
  assign trial = {rem_r, quo_r[HGT_W-1]};

  assign status.need_div = (in_req_type == REQ_ENQ) && (count_r != '0);
  assign status.div_last = (step_r == STEP_W'(AVG_STEPS - 1));

  assign is_enq   = (req_r == REQ_ENQ);
  assign evict    = is_enq && (count_r >= ecap);
  assign drop     = evict || (!is_enq && (count_r != '0));
  assign head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
  assign head_a   = drop ? head_inc : head_r;
  assign count_a  = drop ? count_r - CW'(1) : count_r;
  assign sum_a    = drop ? sum_r - SW'(rd_hgt_r) : sum_r;
  assign tail_sum = {1'b0, head_a} + (IW + 1)'(count_a);
  assign tail     = (tail_sum >= (IW + 1)'(DEPTH)) ? IW'(tail_sum - (IW + 1)'(DEPTH))
                                                   : tail_sum[IW-1:0];

  always_comb begin
    head_nxt  = head_a;
    count_nxt = count_a;
    sum_nxt   = sum_a;
    if (is_enq) begin
      count_nxt = count_a + CW'(1);
      sum_nxt   = sum_a + SW'(hgt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && is_enq) begin
      id_mem[tail]  <= id_r;
      hgt_mem[tail] <= hgt_r;
    end
    rd_id_r  <= id_mem[head_r];
    rd_hgt_r <= hgt_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.apply) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
      out_valid_r <= cmd.apply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      id_r   <= in_player_id;
      hgt_r  <= in_height;
      rem_r  <= num[NW-1:HGT_W];
      quo_r  <= num[HGT_W-1:0];
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + STEP_W'(1);
      if (trial >= {1'b0, den}) begin
        rem_r <= RW'(trial - {1'b0, den});
        quo_r <= {quo_r[HGT_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[RW-1:0];
        quo_r <= {quo_r[HGT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      avg_valid_r      <= is_enq && (count_r != '0);
      avg_height_r     <= (is_enq && (count_r != '0)) ? quo_r : '0;
      removed_valid_r  <= !is_enq && (count_r != '0);
      removed_id_r     <= (!is_enq && (count_r != '0)) ? rd_id_r : '0;
      removed_height_r <= (!is_enq && (count_r != '0)) ? rd_hgt_r : '0;
      empty_error_r    <= !is_enq && (count_r == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_avg_valid      = avg_valid_r;
  assign out_avg_height     = avg_height_r;
  assign out_removed_valid  = removed_valid_r;
  assign out_removed_id     = removed_id_r;
  assign out_removed_height = removed_height_r;
  assign out_empty_error    = empty_error_r;

endmodule

// File: rtl/bounded_fifo_with_average_core.sv
// Bounded queue of (id, height) records with a running average of the held heights.
// A request is taken when start is high and busy is low. A dequeue, or an enqueue
// into an empty queue, goes straight from the transfer to the apply state, while an
// enqueue into a non-empty queue runs the 8-step restoring divider that forms the
// rounded average. Each result is shown for exactly one cycle with out_valid high
// and cannot be held off, so the receiver must take it then; a new request may
// be started in that same cycle. An enqueue on a full queue drops the oldest
// record without a result of its own, and a dequeue on an empty queue returns
// out_empty_error. Write the capacity only while busy is low.
module bounded_fifo_with_average_core
  import bfa_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [ID_W-1:0]  in_player_id,
  input  logic [HGT_W-1:0] in_height,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output logic             out_valid,
  output logic             out_avg_valid,
  output logic [HGT_W-1:0] out_avg_height,
  output logic             out_removed_valid,
  output logic [ID_W-1:0]  out_removed_id,
  output logic [HGT_W-1:0] out_removed_height,
  output logic             out_empty_error
);

  bfa_cmd_t    cmd;
  bfa_status_t status;

  bfa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bfa_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_req_type        (in_req_type),
    .in_player_id       (in_player_id),
    .in_height          (in_height),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_avg_valid      (out_avg_valid),
    .out_avg_height     (out_avg_height),
    .out_removed_valid  (out_removed_valid),
    .out_removed_id     (out_removed_id),
    .out_removed_height (out_removed_height),
    .out_empty_error    (out_empty_error)
  );

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_avg_valid, out_removed_valid, out_empty_error}) <= 1)
    else $error("result carries more than one outcome");

  a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid && !busy)
    else $error("applied request did not produce a result");

  a_result_only_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.apply))
    else $error("result strobe without an applied request");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

endmodule

// File: tb/tb_bounded_fifo_with_average_core.sv
`timescale 1ns / 1ps

module tb_bounded_fifo_with_average_core
  import bfa_pkg::*;
();

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic             avg_valid;
    logic [HGT_W-1:0] avg_height;
    logic             removed_valid;
    logic [ID_W-1:0]  removed_id;
    logic [HGT_W-1:0] removed_height;
    logic             empty_error;
  } fifo_result_t;

  class queue_tracker;
    logic [ID_W-1:0]  held_id [DEPTH_DEF];
    logic [HGT_W-1:0] held_height [DEPTH_DEF];
    int unsigned      head_ptr;
    int unsigned      held_count;
    int unsigned      height_total;
    logic [CAP_W-1:0] cap_setting;
    fifo_result_t     awaited[$];
    int unsigned      results_seen;
    int unsigned      mismatches;

    function new();
      head_ptr     = 0;
      held_count   = 0;
      height_total = 0;
      cap_setting  = CAP_RESET;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      cap_setting = value;
    endfunction

    function int unsigned effective_cap();
      if (cap_setting == 0) return 1;
      if (cap_setting > DEPTH_DEF) return DEPTH_DEF;
      return 32'(cap_setting);
    endfunction

    function void drop_oldest();
      height_total = height_total - held_height[head_ptr];
      head_ptr     = (head_ptr + 1) % DEPTH_DEF;
      held_count   = held_count - 1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(logic req, logic [ID_W-1:0] pid, logic [HGT_W-1:0] hgt);
      fifo_result_t want;
      int unsigned  slot;
      int unsigned  num;
      int unsigned  den;
      want = '0;
      if (req == REQ_ENQ) begin
        if (held_count != 0) begin
          num             = 2 * height_total + held_count;
          den             = 2 * held_count;
          want.avg_valid  = 1'b1;
          want.avg_height = HGT_W'(num / den);
        end
        if (held_count >= effective_cap()) drop_oldest();
        slot              = (head_ptr + held_count) % DEPTH_DEF;
        held_id[slot]     = pid;
        held_height[slot] = hgt;
        height_total      = height_total + hgt;
        held_count        = held_count + 1;
      end else if (held_count == 0) begin
        want.empty_error = 1'b1;
      end else begin
        want.removed_valid  = 1'b1;
        want.removed_id     = held_id[head_ptr];
        want.removed_height = held_height[head_ptr];
        drop_oldest();
      end
      awaited.push_back(want);
    endfunction

    task report(string what, logic [15:0] want, logic [15:0] got);
      $display("mismatch at result %0d: %s expected %h, got %h",
               results_seen, what, want, got);
      mismatches++;
    endtask

    task check_result(fifo_result_t got);
      fifo_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report("unrequested result", 16'h0, 16'h1);
      end else begin
        want = awaited.pop_front();
        if (got.avg_valid !== want.avg_valid)
          report("avg_valid", 16'(want.avg_valid), 16'(got.avg_valid));
        if (got.avg_height !== want.avg_height)
          report("avg_height", 16'(want.avg_height), 16'(got.avg_height));
        if (got.removed_valid !== want.removed_valid)
          report("removed_valid", 16'(want.removed_valid), 16'(got.removed_valid));
        if (got.removed_id !== want.removed_id)
          report("removed_id", 16'(want.removed_id), 16'(got.removed_id));
        if (got.removed_height !== want.removed_height)
          report("removed_height", 16'(want.removed_height), 16'(got.removed_height));
        if (got.empty_error !== want.empty_error)
          report("empty_error", 16'(want.empty_error), 16'(got.empty_error));
      end
    endtask

    task check_leftovers();
      if (awaited.size() != 0)
        report("results never delivered", 16'(awaited.size()), 16'h0);
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_req_type;
  logic [ID_W-1:0]  in_player_id;
  logic [HGT_W-1:0] in_height;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             out_valid;
  logic             out_avg_valid;
  logic [HGT_W-1:0] out_avg_height;
  logic             out_removed_valid;
  logic [ID_W-1:0]  out_removed_id;
  logic [HGT_W-1:0] out_removed_height;
  logic             out_empty_error;

  queue_tracker tracker;
  bit           idle_on;
  int unsigned  quiet_cycles;

  bounded_fifo_with_average_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_player_id      (in_player_id),
    .in_height         (in_height),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_avg_valid     (out_avg_valid),
    .out_avg_height    (out_avg_height),
    .out_removed_valid (out_removed_valid),
    .out_removed_id    (out_removed_id),
    .out_removed_height(out_removed_height),
    .out_empty_error   (out_empty_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result({out_avg_valid, out_avg_height, out_removed_valid,
                            out_removed_id, out_removed_height, out_empty_error});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bounded_fifo_with_average_core regression: fail");
      $finish;
    end
  end

  task automatic send_request(input logic req, input logic [ID_W-1:0] pid,
                              input logic [HGT_W-1:0] hgt);
    in_req_type  <= req;
    in_player_id <= pid;
    in_height    <= hgt;
    forever begin
      start <= !(idle_on && ($urandom_range(99) < 28));
      @(posedge clk);
      if (start && !busy) break;
    end
    tracker.note_request(req, pid, hgt);
  endtask

  task automatic enqueue(input logic [ID_W-1:0] pid, input logic [HGT_W-1:0] hgt);
    send_request(REQ_ENQ, pid, hgt);
  endtask

  task automatic dequeue();
    send_request(REQ_DEQ, ID_W'($urandom), HGT_W'($urandom));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (tracker.pending() == 0 && !busy) break;
    end
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_capacity(value);
  endtask

  task automatic random_requests(input int count);
    int               mode;
    int               enq_pct;
    int               pick;
    logic [HGT_W-1:0] hgt;
    mode = 2;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) mode = $urandom_range(2);
      enq_pct = (mode == 0) ? 85 : (mode == 1) ? 20 : 55;
      pick    = $urandom_range(9);
      hgt     = (pick == 0) ? '0 : (pick == 1) ? '1 : HGT_W'($urandom);
      if ($urandom_range(99) < enq_pct) begin
        enqueue(ID_W'($urandom), hgt);
      end else begin
        dequeue();
      end
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan [16];
    cap_plan     = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd6, 4'd2, 4'd10,
                     4'd4, 4'd12, 4'd8, 4'd5, 4'd7, 4'd9, 4'd2, 4'd11};
    tracker      = new();
    idle_on      = 1'b1;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = REQ_ENQ;
    in_player_id = '0;
    in_height    = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty error, rounding, eviction, then a full drain.
    dequeue();
    enqueue(12'h000, 8'd0);
    enqueue(12'hFFF, 8'd255);
    enqueue(12'hA5A, 8'd255);
    enqueue(12'h5A5, 8'd128);
    enqueue(12'h001, 8'd1);
    enqueue(12'h002, 8'd2);
    repeat (5) dequeue();
    dequeue();

    // A capacity of zero behaves as one.
    write_capacity(4'd0);
    enqueue(12'h123, 8'd77);
    enqueue(12'h456, 8'd78);
    dequeue();
    dequeue();

    // Capacity above the depth, then lowered while the queue is full.
    write_capacity(4'd15);
    for (int i = 0; i < DEPTH_DEF + 1; i++) enqueue(ID_W'(i * 455), 8'd255);
    write_capacity(4'd2);
    enqueue(12'h800, 8'd0);
    dequeue();
    dequeue();

    for (int p = 0; p < 16; p++) begin
      write_capacity(cap_plan[p]);
      idle_on = !(p == 6 || p == 7);
      random_requests(96);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    tracker.check_leftovers();
    if (tracker.mismatches == 0) begin
      $display("bounded_fifo_with_average_core regression: pass");
    end else begin
      $display("bounded_fifo_with_average_core regression: fail");
    end
    $finish;
  end

endmodule
